@@ hdl/mmic_pkg.sv @@
`timescale 1ns / 1ps

package mmic_pkg;

	localparam int WORD_W    = 32;
	localparam int ADDR_W    = 48;
	localparam int NUM_SLOTS = 4;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int ROUND_W   = 2;

	localparam logic [7:0] PAD_BYTE = 8'h5a;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_DATA  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	typedef enum logic [ROUND_W-1:0] {
		RND_ROT17 = 2'd0,
		RND_SWAP  = 2'd1,
		RND_ROT3  = 2'd2,
		RND_ROT30 = 2'd3
	} round_t;

	typedef struct packed {
		logic [WORD_W-1:0] left;
		logic [WORD_W-1:0] right;
	} mic_pair_t;

endpackage

@@ hdl/mmic_round.sv @@
`timescale 1ns / 1ps

module mmic_round
	import mmic_pkg::*;
(
	input  mic_pair_t         cur,
	input  logic [WORD_W-1:0] word,
	input  round_t            round,
	output mic_pair_t         nxt
);

	logic [WORD_W-1:0] l_in;
	logic [WORD_W-1:0] mixed;
	logic [WORD_W-1:0] r_new;

	// message word enters before the first round of each block
	assign l_in = (round == RND_ROT17) ? (cur.left ^ word) : cur.left;

	always_comb begin
		case (round)
			RND_ROT17: mixed = {l_in[14:0], l_in[31:15]};
			RND_SWAP:  mixed = {l_in[23:16], l_in[31:24], l_in[7:0], l_in[15:8]};
			RND_ROT3:  mixed = {l_in[28:0], l_in[31:29]};
			RND_ROT30: mixed = {l_in[1:0], l_in[31:2]};
			default:   mixed = l_in;
		endcase
	end

	assign r_new     = cur.right ^ mixed;
	assign nxt.right = r_new;
	assign nxt.left  = l_in + r_new;

endmodule

@@ hdl/michael_mic_engine.sv @@
`timescale 1ns / 1ps

// michael mic engine
// input channel: in_valid / in_ready, one item per handshake
//   command start: loads key_left / key_right and mixes the header filler
//   (dest_addr, src_addr, four zero bytes), no result
//   command data: mixes data_word; with last set, pads valid_bytes bytes with
//   0x5a and zeros and gives one result item on mic_left / mic_right
// output channel: out_valid / out_ready, result held in an output register
// timing: one shared block-function round unit, one round per cycle, four
//   rounds per 32-bit word
//   start item: four header words, data item: one word, last item: two words
//   (valid_bytes below four) or three, then the hold state loads the result
//   in_ready is high only while idle, so one item is at work at a time
// a finished result waits in the output register; the next item is accepted
//   meanwhile, and a following last item waits until out_ready frees the slot
// reset clears the mic state words to zero and drops out_valid

module michael_mic_engine
	import mmic_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              command,
	input  logic [WORD_W-1:0] key_left,
	input  logic [WORD_W-1:0] key_right,
	input  logic [ADDR_W-1:0] dest_addr,
	input  logic [ADDR_W-1:0] src_addr,
	input  logic [WORD_W-1:0] data_word,
	input  logic [2:0]        valid_bytes,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] mic_left,
	output logic [WORD_W-1:0] mic_right
);

	state_t            state_q;
	mic_pair_t         mic_q;
	mic_pair_t         mic_nxt;
	mic_pair_t         out_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] slot_q [NUM_SLOTS];
	logic [WORD_W-1:0] slot_d [NUM_SLOTS];
	logic [SLOT_W-1:0] slot_idx_q;
	logic [SLOT_W-1:0] slot_last_q;
	logic [SLOT_W-1:0] slot_last_d;
	round_t            round_q;
	logic              emit_q;
	logic              accept;
	logic [WORD_W-1:0] padded;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign mic_left  = out_q.left;
	assign mic_right = out_q.right;

	always_comb begin
		case (valid_bytes[1:0])
			2'd0:    padded = {24'h0, PAD_BYTE};
			2'd1:    padded = {16'h0, PAD_BYTE, data_word[7:0]};
			2'd2:    padded = {8'h0, PAD_BYTE, data_word[15:0]};
			2'd3:    padded = {PAD_BYTE, data_word[23:0]};
			default: padded = data_word;
		endcase
	end

	// words to mix for the accepted item
	always_comb begin
		slot_d[0]   = data_word;
		slot_d[1]   = '0;
		slot_d[2]   = '0;
		slot_d[3]   = '0;
		slot_last_d = SLOT_W'(0);
		if (command == CMD_START) begin
			slot_d[0]   = dest_addr[31:0];
			slot_d[1]   = {src_addr[15:0], dest_addr[47:32]};
			slot_d[2]   = src_addr[47:16];
			slot_last_d = SLOT_W'(3);
		end else if (last) begin
			if (valid_bytes[2]) begin
				slot_d[1]   = {24'h0, PAD_BYTE};
				slot_last_d = SLOT_W'(2);
			end else begin
				slot_d[0]   = padded;
				slot_last_d = SLOT_W'(1);
			end
		end
	end

	mmic_round u_round (
		.cur   (mic_q),
		.word  (slot_q[slot_idx_q]),
		.round (round_q),
		.nxt   (mic_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mic_q       <= '0;
			out_valid_q <= 1'b0;
			slot_idx_q  <= '0;
			slot_last_q <= '0;
			round_q     <= RND_ROT17;
			emit_q      <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_HOLD) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (command == CMD_START) begin
							mic_q <= '{left: key_left, right: key_right};
						end
						slot_idx_q  <= '0;
						slot_last_q <= slot_last_d;
						round_q     <= RND_ROT17;
						emit_q      <= (command == CMD_DATA) && last;
						state_q     <= ST_RUN;
					end
				end
				ST_RUN: begin
					mic_q   <= mic_nxt;
					round_q <= round_t'(round_q + 1'b1);
					if (round_q == RND_ROT30) begin
						slot_idx_q <= slot_idx_q + 1'b1;
						if (slot_idx_q == slot_last_q) begin
							state_q <= emit_q ? ST_HOLD : ST_IDLE;
						end
					end
				end
				ST_HOLD: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q <= slot_d;
		end
		if (state_q == ST_HOLD && (!out_valid_q || out_ready)) begin
			out_q <= mic_q;
		end
	end

endmodule

@@ hdl/mmic_checker.sv @@
`timescale 1ns / 1ps

module mmic_checker
	import mmic_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              command,
	input logic              last,
	input logic              out_valid,
	input logic              out_ready,
	input logic [WORD_W-1:0] mic_left,
	input logic [WORD_W-1:0] mic_right
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mic_left) && $stable(mic_right))
		else $error("result changed while stalled");

	// start item keeps the engine busy through the rounds of its four header words
	a_start_len: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_START |=> !in_ready ##16 in_ready)
		else $error("start item length wrong");

	// plain data item keeps the engine busy through the rounds of its single word
	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_DATA && !last |=> !in_ready ##4 in_ready)
		else $error("data item length wrong");

	// a result appears only at the end of a busy stretch
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without work");

endmodule

bind michael_mic_engine mmic_checker u_mmic_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.command   (command),
	.last      (last),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.mic_left  (mic_left),
	.mic_right (mic_right)
);
